// ----- rtl/rrsp_pkg.sv -----
// Shared types, codes and defaults for the round-robin status poller.
package rrsp_pkg;

    // Default sizing
    localparam int MAX_AGENTS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;

    // Field widths
    localparam int ID_W    = 4;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int CFG_W   = 16;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLY     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_POLL     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACOUSTIC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DIRECT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NODE_TO  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DRV_TO   = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_AGENT_MASK   = 3'd0;
    localparam logic [2:0] REG_POLL_PERIOD  = 3'd1;
    localparam logic [2:0] REG_RESP_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_DIRECT_TO    = 3'd3;
    localparam logic [2:0] REG_EN_DIRECT    = 3'd4;
    localparam logic [2:0] REG_EN_ACOUSTIC  = 3'd5;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_AGENT_MASK   = 16'd0;
    localparam logic [CFG_W-1:0] RST_POLL_PERIOD  = 16'd10;
    localparam logic [CFG_W-1:0] RST_RESP_TIMEOUT = 16'd50;
    localparam logic [CFG_W-1:0] RST_DIRECT_TO    = 16'd30;
    localparam logic             RST_EN_DIRECT    = 1'b0;
    localparam logic             RST_EN_ACOUSTIC  = 1'b1;

    // Result buffer depth
    localparam int RES_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ID_W-1:0]  src_id;
        logic             for_local;
        logic             decode_ok;
        logic             driver_timeout;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   agent_id;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] agent_mask;
        logic [CFG_W-1:0] poll_period_ticks;
        logic [CFG_W-1:0] response_timeout_ticks;
        logic [CFG_W-1:0] direct_timeout_ticks;
        logic             enable_direct;
        logic             enable_acoustic;
    } t_cfg;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  r0;
        t_out_item  r1;
    } t_push;

endpackage

// ----- rtl/rrsp_cfg.sv -----
// APB configuration register file for the status poller.
module rrsp_cfg
    import rrsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.agent_mask             <= RST_AGENT_MASK;
            r_cfg.poll_period_ticks      <= RST_POLL_PERIOD;
            r_cfg.response_timeout_ticks <= RST_RESP_TIMEOUT;
            r_cfg.direct_timeout_ticks   <= RST_DIRECT_TO;
            r_cfg.enable_direct          <= RST_EN_DIRECT;
            r_cfg.enable_acoustic        <= RST_EN_ACOUSTIC;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_AGENT_MASK:   r_cfg.agent_mask             <= pwdata[CFG_W-1:0];
                REG_POLL_PERIOD:  r_cfg.poll_period_ticks      <= pwdata[CFG_W-1:0];
                REG_RESP_TIMEOUT: r_cfg.response_timeout_ticks <= pwdata[CFG_W-1:0];
                REG_DIRECT_TO:    r_cfg.direct_timeout_ticks   <= pwdata[CFG_W-1:0];
                REG_EN_DIRECT:    r_cfg.enable_direct          <= pwdata[0];
                REG_EN_ACOUSTIC:  r_cfg.enable_acoustic        <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_AGENT_MASK:   prdata = APB_DW'(r_cfg.agent_mask);
            REG_POLL_PERIOD:  prdata = APB_DW'(r_cfg.poll_period_ticks);
            REG_RESP_TIMEOUT: prdata = APB_DW'(r_cfg.response_timeout_ticks);
            REG_DIRECT_TO:    prdata = APB_DW'(r_cfg.direct_timeout_ticks);
            REG_EN_DIRECT:    prdata = APB_DW'(r_cfg.enable_direct);
            REG_EN_ACOUSTIC:  prdata = APB_DW'(r_cfg.enable_acoustic);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/rrsp_res_fifo.sv -----
// Result buffer: takes up to two results per cycle, hands out one per cycle while the receiver is ready.
module rrsp_res_fifo
    import rrsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_space_ok,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int DEPTH = RES_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_out_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wp1;
    logic             pop;
    logic [CNT_W-1:0] left_after_pop;

    assign o_valid        = (r_count != '0);
    assign o_data         = r_mem[r_rp];
    assign pop            = o_valid && i_ready;
    assign wp1            = r_wp + 1'b1;
    assign left_after_pop = r_count - CNT_W'(pop);
    // room for a full pair of results
    assign o_space_ok     = (left_after_pop <= CNT_W'(DEPTH - 2));

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(i_push.cnt);
            r_rp    <= r_rp + PTR_W'(pop);
            r_count <= left_after_pop + CNT_W'(i_push.cnt);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result buffer overfilled");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (left_after_pop + CNT_W'(i_push.cnt) <= CNT_W'(DEPTH)))
        else $error("push without room");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt == 2'd2) |-> (i_push.r1.last_of_run && !i_push.r0.last_of_run))
        else $error("pair end marker misplaced");

endmodule

// ----- rtl/rrsp_core.sv -----
// Poller state, request register and single-pass event processing.
module rrsp_core
    import rrsp_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    input  logic     i_space_ok,
    output t_push    o_push
);

    localparam int IDX_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int TW    = TIME_WIDTH;

    // Request register
    logic     r_in_vld;
    t_in_item r_in;
    logic     fire;

    // Poller state
    logic [TW-1:0]         r_time;
    logic                  r_awaiting;
    logic [ID_W-1:0]       r_pending;
    logic [TW-1:0]         r_req_stamp;
    logic [TW-1:0]         r_allowed;
    logic [IDX_W-1:0]      r_next_slot;
    logic [TW-1:0]         r_hb_stamp [MAX_AGENTS];
    logic [MAX_AGENTS-1:0] r_hb_seen;

    // Next values
    logic                  n_awaiting;
    logic [ID_W-1:0]       n_pending;
    logic [TW-1:0]         n_req_stamp;
    logic [TW-1:0]         n_allowed;
    logic [IDX_W-1:0]      n_next_slot;

    // Working signals
    logic [MAX_AGENTS-1:0] live;
    logic [MAX_AGENTS-1:0] live_hi;
    logic [TW-1:0]         t_cur;
    logic [TW-1:0]         hold_at;
    logic                  id_marked;
    logic                  pend_marked;
    logic                  pend_match;
    logic                  aw0;
    logic [TW-1:0]         allow0;
    logic                  e0_vld;
    logic [KIND_W-1:0]     e0_kind;
    logic [ID_W-1:0]       e0_id;
    logic                  run_poll;
    logic                  hb_wr;
    logic [IDX_W-1:0]      pid;
    logic [TW-1:0]         hb_age;
    logic                  fresh;
    logic                  poll_go;
    logic                  poll_emit;
    t_out_item             res_e0;
    t_out_item             res_poll;

    function automatic logic [IDX_W-1:0] f_lowest(input logic [MAX_AGENTS-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_AGENTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign fire       = r_in_vld && i_space_ok;
    assign o_in_ready = !r_in_vld || fire;

    // Request register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in <= '0;
        end else if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Common terms
    assign live        = i_cfg.agent_mask[MAX_AGENTS-1:0];
    assign t_cur       = (r_in.command == CMD_TICK) ? r_time + 1'b1 : r_time;
    assign hold_at     = t_cur + TW'(i_cfg.poll_period_ticks);
    assign id_marked   = (32'(r_in.src_id) < MAX_AGENTS)
                         && live[r_in.src_id[IDX_W-1:0]];
    assign pend_marked = (32'(r_pending) < MAX_AGENTS) && live[r_pending[IDX_W-1:0]];
    assign pend_match  = r_awaiting && (r_in.src_id == r_pending);

    // Event handling ahead of the poll step
    always_comb begin
        aw0      = r_awaiting;
        allow0   = r_allowed;
        e0_vld   = 1'b0;
        e0_kind  = KIND_POLL;
        e0_id    = r_pending;
        run_poll = 1'b0;
        hb_wr    = 1'b0;
        unique case (r_in.command)
            CMD_TICK: begin
                run_poll = 1'b1;
                if (r_awaiting
                    && ((t_cur - r_req_stamp) > TW'(i_cfg.response_timeout_ticks))) begin
                    e0_vld  = 1'b1;
                    e0_kind = KIND_NODE_TO;
                    aw0     = 1'b0;
                    allow0  = hold_at;
                end
            end
            CMD_REPLY: begin
                if (pend_match && r_in.for_local) begin
                    if (!pend_marked) begin
                        // agent dropped from the mask: end quietly, no holdoff
                        aw0 = 1'b0;
                    end else if (r_in.decode_ok) begin
                        e0_vld   = 1'b1;
                        e0_kind  = KIND_ACOUSTIC;
                        aw0      = 1'b0;
                        allow0   = hold_at;
                        run_poll = 1'b1;
                    end
                end
            end
            CMD_UPDATE: begin
                if (pend_match && r_in.driver_timeout) begin
                    e0_vld   = 1'b1;
                    e0_kind  = KIND_DRV_TO;
                    aw0      = 1'b0;
                    allow0   = hold_at;
                    run_poll = 1'b1;
                end
            end
            CMD_HEARTBEAT: begin
                if (i_cfg.enable_direct && id_marked) begin
                    hb_wr   = 1'b1;
                    e0_vld  = 1'b1;
                    e0_kind = KIND_DIRECT;
                    e0_id   = r_in.src_id;
                end
            end
        endcase
    end

    // Round-robin pick: lowest marked id at or after the next slot, else wrap
    always_comb begin
        for (int i = 0; i < MAX_AGENTS; i++) begin
            live_hi[i] = live[i] && (IDX_W'(i) >= r_next_slot);
        end
    end

    assign pid     = (|live_hi) ? f_lowest(live_hi) : f_lowest(live);
    assign hb_age  = t_cur - r_hb_stamp[pid];
    assign fresh   = i_cfg.enable_direct && r_hb_seen[pid]
                     && (hb_age < TW'(i_cfg.direct_timeout_ticks));
    assign poll_go = run_poll && !aw0 && (|live) && !(t_cur < allow0);

    // Poll step
    always_comb begin
        n_awaiting  = aw0;
        n_pending   = r_pending;
        n_req_stamp = r_req_stamp;
        n_allowed   = allow0;
        n_next_slot = r_next_slot;
        poll_emit   = 1'b0;
        if (poll_go) begin
            n_next_slot = (pid == IDX_W'(MAX_AGENTS - 1)) ? '0 : pid + 1'b1;
            if (fresh || !i_cfg.enable_acoustic) begin
                n_allowed = hold_at;
            end else begin
                poll_emit   = 1'b1;
                n_awaiting  = 1'b1;
                n_pending   = ID_W'(pid);
                n_req_stamp = t_cur;
            end
        end
    end

    // Result packing
    always_comb begin
        res_e0.kind          = e0_kind;
        res_e0.agent_id      = e0_id;
        res_e0.last_of_run   = !poll_emit;
        res_poll.kind        = KIND_POLL;
        res_poll.agent_id    = ID_W'(pid);
        res_poll.last_of_run = 1'b1;
        o_push.cnt = fire ? (2'(e0_vld) + 2'(poll_emit)) : 2'd0;
        o_push.r0  = e0_vld ? res_e0 : res_poll;
        o_push.r1  = res_poll;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_awaiting  <= 1'b0;
            r_pending   <= '0;
            r_req_stamp <= '0;
            r_allowed   <= '0;
            r_next_slot <= '0;
            r_hb_seen   <= '0;
        end else if (fire) begin
            r_time      <= t_cur;
            r_awaiting  <= n_awaiting;
            r_pending   <= n_pending;
            r_req_stamp <= n_req_stamp;
            r_allowed   <= n_allowed;
            r_next_slot <= n_next_slot;
            if (hb_wr) begin
                r_hb_seen[r_in.src_id[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // Heartbeat stamps, guarded by the seen bits
    always_ff @(posedge i_clk) begin
        if (fire && hb_wr) begin
            r_hb_stamp[r_in.src_id[IDX_W-1:0]] <= r_time;
        end
    end

    a_poll_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && poll_emit) |=> (r_awaiting && (r_pending == ID_W'($past(pid)))))
        else $error("poll sent without arming the request");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> ($stable(r_time) && $stable(r_awaiting) && $stable(r_next_slot)))
        else $error("state moved without a request");

    a_pair_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> ((o_push.r1.kind == KIND_POLL)
            && ((o_push.r0.kind == KIND_NODE_TO) || (o_push.r0.kind == KIND_ACOUSTIC)
                || (o_push.r0.kind == KIND_DRV_TO))))
        else $error("unexpected result pair");

endmodule

// ----- rtl/round_robin_status_poller_unit.sv -----
// Top level of the round-robin status poller: config port, core and result buffer.
// Flow: an accepted request is held in the request register until the result buffer
//   has room for a pair of results, then processed; its results pass through the buffer.
// Throughput: one request per cycle while the buffer has that room; the output port
//   moves one result per cycle while the receiver is ready.
// Reset: synchronous, active low; clears poller state and loads register defaults.
module round_robin_status_poller_unit
    import rrsp_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    t_cfg  cfg;
    t_push push;
    logic  space_ok;

    // Configuration registers
    rrsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Event processing
    rrsp_core #(
        .MAX_AGENTS (MAX_AGENTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_space_ok (space_ok),
        .o_push     (push)
    );

    // Result buffer
    rrsp_res_fifo u_res (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

endmodule

// ----- tb/rrsp_status_checker.sv -----
// Checker for the round-robin status poller: tracks config writes, predicts and compares results.
module rrsp_status_checker
    import rrsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic              i_pready,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  t_in_item          i_req,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  t_out_item         i_rsp,
    output int                o_mismatches,
    output int                o_reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the register file
    t_cfg        cfg;

    // Poller state
    logic [31:0] clock_now;
    logic        awaiting;
    logic [3:0]  pending_id;
    logic [31:0] req_stamp;
    logic [31:0] poll_ready_at;
    logic [3:0]  rr_slot;
    logic [31:0] hb_stamp [16];
    logic        hb_seen  [16];

    // Results of the request being predicted, then the in-order store of what is due
    t_out_item   step_out [2];
    int          step_n;
    t_out_item   due_reports [$];
    int          reports_seen;

    initial begin
        o_mismatches  = 0;
        o_reports_due = 0;
        reports_seen  = 0;
    end

    task automatic flag_mismatch(input string msg);
        o_mismatches = o_mismatches + 1;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic add_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        step_out[step_n].kind        = kind;
        step_out[step_n].agent_id    = id;
        step_out[step_n].last_of_run = 1'b0;
        step_n = step_n + 1;
    endtask

    task automatic hold_off();
        poll_ready_at = clock_now + {16'd0, cfg.poll_period_ticks};
    endtask

    task automatic close_request();
        awaiting = 1'b0;
        hold_off();
    endtask

    // Round-robin pick of the next marked agent, then skip, poll or hold off
    task automatic try_poll();
        logic [3:0]  id;
        logic [3:0]  cand;
        logic        found;
        logic [31:0] age;
        if (awaiting || cfg.agent_mask == '0 || clock_now < poll_ready_at) begin
            return;
        end
        found = 1'b0;
        id    = '0;
        for (int k = 0; k < 16; k++) begin
            cand = rr_slot + 4'(k);
            if (!found && cfg.agent_mask[cand]) begin
                id    = cand;
                found = 1'b1;
            end
        end
        if (!found) begin
            return;
        end
        rr_slot = id + 4'd1;
        age = clock_now - hb_stamp[id];
        if (cfg.enable_direct && hb_seen[id] && age < {16'd0, cfg.direct_timeout_ticks}) begin
            hold_off();
            return;
        end
        if (cfg.enable_acoustic) begin
            add_result(KIND_POLL, id);
            awaiting   = 1'b1;
            pending_id = id;
            req_stamp  = clock_now;
            return;
        end
        hold_off();
    endtask

    // One accepted request: update the state and queue what it causes
    task automatic advance_poller(input t_in_item req);
        logic [31:0] age;
        step_n = 0;
        case (req.command)
            CMD_TICK: begin
                clock_now = clock_now + 32'd1;
                age = clock_now - req_stamp;
                if (awaiting && age > {16'd0, cfg.response_timeout_ticks}) begin
                    add_result(KIND_NODE_TO, pending_id);
                    close_request();
                end
                try_poll();
            end
            CMD_REPLY: begin
                if (awaiting && req.for_local && req.src_id == pending_id) begin
                    // agent dropped from the mask: forget the request quietly
                    if (!cfg.agent_mask[pending_id]) begin
                        awaiting = 1'b0;
                    end else if (req.decode_ok) begin
                        add_result(KIND_ACOUSTIC, pending_id);
                        close_request();
                        try_poll();
                    end
                end
            end
            CMD_UPDATE: begin
                if (awaiting && req.src_id == pending_id && req.driver_timeout) begin
                    add_result(KIND_DRV_TO, pending_id);
                    close_request();
                    try_poll();
                end
            end
            default: begin
                if (cfg.enable_direct && cfg.agent_mask[req.src_id]) begin
                    hb_stamp[req.src_id] = clock_now;
                    hb_seen[req.src_id]  = 1'b1;
                    add_result(KIND_DIRECT, req.src_id);
                end
            end
        endcase
        if (step_n > 0) begin
            step_out[step_n-1].last_of_run = 1'b1;
            for (int i = 0; i < step_n; i++) begin
                due_reports.insert(due_reports.size(), step_out[i]);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            cfg.agent_mask             = RST_AGENT_MASK;
            cfg.poll_period_ticks      = RST_POLL_PERIOD;
            cfg.response_timeout_ticks = RST_RESP_TIMEOUT;
            cfg.direct_timeout_ticks   = RST_DIRECT_TO;
            cfg.enable_direct          = RST_EN_DIRECT;
            cfg.enable_acoustic        = RST_EN_ACOUSTIC;
            clock_now     = '0;
            awaiting      = 1'b0;
            pending_id    = '0;
            req_stamp     = '0;
            poll_ready_at = '0;
            rr_slot       = '0;
            for (int i = 0; i < 16; i++) begin
                hb_stamp[i] = '0;
                hb_seen[i]  = 1'b0;
            end
            due_reports.delete();
        end else begin
            // Register write completes on the access cycle
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_AGENT_MASK:   cfg.agent_mask             = i_pwdata[15:0];
                    REG_POLL_PERIOD:  cfg.poll_period_ticks      = i_pwdata[15:0];
                    REG_RESP_TIMEOUT: cfg.response_timeout_ticks = i_pwdata[15:0];
                    REG_DIRECT_TO:    cfg.direct_timeout_ticks   = i_pwdata[15:0];
                    REG_EN_DIRECT:    cfg.enable_direct          = i_pwdata[0];
                    REG_EN_ACOUSTIC:  cfg.enable_acoustic        = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                advance_poller(i_req);
            end
            // Compare each accepted result with the oldest one due
            if (i_rsp_valid && i_rsp_ready) begin
                reports_seen = reports_seen + 1;
                if (due_reports.size() == 0) begin
                    flag_mismatch($sformatf("result %0d unexpected: kind %0d agent %0d last %0b",
                        reports_seen, i_rsp.kind, i_rsp.agent_id, i_rsp.last_of_run));
                end else begin
                    want = due_reports.pop_front();
                    if (i_rsp.kind != want.kind) begin
                        flag_mismatch($sformatf("result %0d kind: got %0d want %0d",
                            reports_seen, i_rsp.kind, want.kind));
                    end
                    if (i_rsp.agent_id != want.agent_id) begin
                        flag_mismatch($sformatf("result %0d agent_id: got %0d want %0d",
                            reports_seen, i_rsp.agent_id, want.agent_id));
                    end
                    if (i_rsp.last_of_run != want.last_of_run) begin
                        flag_mismatch($sformatf("result %0d last_of_run: got %0b want %0b",
                            reports_seen, i_rsp.last_of_run, want.last_of_run));
                    end
                end
            end
        end
        o_reports_due = due_reports.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the round-robin status poller: clock, reset, stimulus and verdict.
module tb
    import rrsp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 103;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_item          in_data  = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    t_out_item         out_data;

    int                mismatches;
    int                reports_due;
    bit                gaps_on      = 1'b1;
    logic [3:0]        last_poll_id = '0;
    int                stall_left   = 0;
    int                idle_cycles  = 0;

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    round_robin_status_poller_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    rrsp_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_req_valid  (in_valid),
        .i_req_ready  (in_ready),
        .i_req        (in_data),
        .i_rsp_valid  (out_valid),
        .i_rsp_ready  (out_ready),
        .i_rsp        (out_data),
        .o_mismatches (mismatches),
        .o_reports_due(reports_due)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 99) < 20) begin
            stall_left <= gap_len();
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Remember the agent last polled so replies can target it
    always @(posedge i_clk) begin
        if (out_valid && out_ready && out_data.kind == KIND_POLL) begin
            last_poll_id <= out_data.agent_id;
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic t_in_item mk(input logic [1:0] cmd, input logic [3:0] id,
                                    input logic loc, input logic ok, input logic drv);
        t_in_item it;
        it.command        = cmd;
        it.src_id         = id;
        it.for_local      = loc;
        it.decode_ok      = ok;
        it.driver_timeout = drv;
        return it;
    endfunction

    function automatic logic [3:0] pick_marked(input logic [15:0] m);
        logic [3:0] id;
        id = 4'($urandom_range(0, 15));
        for (int tries = 0; tries < 64 && !m[id]; tries++) begin
            id = 4'($urandom_range(0, 15));
        end
        return id;
    endfunction

    // Mostly well-formed traffic: ticks, replies and updates aimed at the polled agent
    function automatic t_in_item next_request(input logic [15:0] m);
        t_in_item    it;
        logic [31:0] rnd;
        int          r;
        rnd = $urandom();
        it  = rnd[$bits(t_in_item)-1:0];
        r   = $urandom_range(0, 99);
        if (r < 45) begin
            it.command = CMD_TICK;
        end else if (r < 72) begin
            it.command = CMD_REPLY;
            if ($urandom_range(0, 9) < 8) begin
                it.src_id    = last_poll_id;
                it.for_local = 1'b1;
                it.decode_ok = ($urandom_range(0, 9) < 8);
            end
        end else if (r < 84) begin
            it.command = CMD_UPDATE;
            if ($urandom_range(0, 9) < 7) it.src_id = last_poll_id;
        end else begin
            it.command = CMD_HEARTBEAT;
            if ($urandom_range(0, 9) < 7) it.src_id = pick_marked(m);
        end
        return it;
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        int   r;
        r = $urandom_range(0, 7);
        case (r)
            0:       c.agent_mask = 16'($urandom());
            1:       c.agent_mask = 16'hFFFF;
            2:       c.agent_mask = 16'h0000;
            default: c.agent_mask = (16'd1 << $urandom_range(0, 15)) |
                                    (16'd1 << $urandom_range(0, 15)) |
                                    (16'd1 << $urandom_range(0, 15));
        endcase
        r = $urandom_range(0, 9);
        c.poll_period_ticks = (r < 7) ? 16'($urandom_range(0, 6)) :
                              (r < 9) ? 16'($urandom_range(7, 40)) : 16'hFFFF;
        r = $urandom_range(0, 9);
        c.response_timeout_ticks = (r < 6) ? 16'($urandom_range(1, 8)) :
                                   (r < 9) ? 16'($urandom_range(9, 60)) : 16'hFFFF;
        r = $urandom_range(0, 9);
        c.direct_timeout_ticks = (r < 5) ? 16'($urandom_range(1, 10)) :
                                 (r < 9) ? 16'($urandom_range(11, 80)) : 16'hFFFF;
        c.enable_direct   = 1'($urandom_range(0, 1));
        c.enable_acoustic = ($urandom_range(0, 99) < 85);
        return c;
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Write every register; unused upper data bits carry noise
    task automatic write_config(input t_cfg c);
        logic [31:0] rnd;
        rnd = $urandom();
        apb_write(REG_AGENT_MASK,   {rnd[31:16], c.agent_mask});
        apb_write(REG_POLL_PERIOD,  {rnd[15:0], c.poll_period_ticks});
        apb_write(REG_RESP_TIMEOUT, {rnd[23:8], c.response_timeout_ticks});
        apb_write(REG_DIRECT_TO,    {rnd[27:12], c.direct_timeout_ticks});
        apb_write(REG_EN_DIRECT,    {rnd[31:1], c.enable_direct});
        apb_write(REG_EN_ACOUSTIC,  {rnd[30:0], c.enable_acoustic});
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_item(input t_in_item it);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send(input t_in_item it);
        int n;
        push_item(it);
        if (gaps_on) begin
            n = gap_len();
            if (n > 0) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    endtask

    // Hold the sender until every due result has arrived, then cover silent requests
    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (reports_due != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        t_cfg cur;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default config, empty mask: everything is ignored
        send(mk(CMD_TICK, 4'd3, 1'b1, 1'b1, 1'b1));
        send(mk(CMD_REPLY, 4'd0, 1'b1, 1'b1, 1'b0));
        send(mk(CMD_UPDATE, 4'd0, 1'b0, 1'b0, 1'b1));
        send(mk(CMD_HEARTBEAT, 4'd0, 1'b0, 1'b0, 1'b0));
        drain_results();

        // Lowest and highest agent, shortest timeout, links never go stale
        cur.agent_mask             = 16'h8001;
        cur.poll_period_ticks      = 16'd0;
        cur.response_timeout_ticks = 16'd1;
        cur.direct_timeout_ticks   = 16'hFFFF;
        cur.enable_direct          = 1'b1;
        cur.enable_acoustic        = 1'b1;
        write_config(cur);
        send(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 1'b0));        // poll agent 0
        send(mk(CMD_REPLY, 4'd0, 1'b0, 1'b1, 1'b0));       // not addressed to us
        send(mk(CMD_REPLY, 4'd15, 1'b1, 1'b1, 1'b0));      // wrong agent
        send(mk(CMD_REPLY, 4'd0, 1'b1, 1'b0, 1'b0));       // bad decode
        send(mk(CMD_REPLY, 4'd0, 1'b1, 1'b1, 1'b0));       // status, then poll 15
        send(mk(CMD_UPDATE, 4'd15, 1'b1, 1'b1, 1'b0));     // update without timeout
        send(mk(CMD_UPDATE, 4'd15, 1'b0, 1'b0, 1'b1));     // driver timeout, poll 0
        send(mk(CMD_TICK, 4'd15, 1'b1, 1'b1, 1'b1));
        send(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 1'b0));        // node timeout, poll 15
        send(mk(CMD_HEARTBEAT, 4'd0, 1'b1, 1'b0, 1'b1));   // direct status
        send(mk(CMD_HEARTBEAT, 4'd5, 1'b0, 1'b1, 1'b0));   // unmarked agent
        send(mk(CMD_REPLY, 4'd15, 1'b1, 1'b1, 1'b1));      // status, agent 0 skipped
        send(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 1'b0));        // poll 15
        drain_results();

        // Drop agent 15 while its request is open
        cur.agent_mask = 16'h0001;
        write_config(cur);
        send(mk(CMD_REPLY, 4'd15, 1'b1, 1'b1, 1'b0));
        send(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 1'b0));        // fresh link skip
        drain_results();
        cur.enable_direct = 1'b0;
        write_config(cur);
        send(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 1'b0));        // poll 0
        drain_results();
        cur.enable_acoustic = 1'b0;
        write_config(cur);
        send(mk(CMD_REPLY, 4'd0, 1'b1, 1'b1, 1'b0));       // status, no new poll
        send(mk(CMD_TICK, 4'd0, 1'b0, 1'b0, 1'b0));
        send(mk(CMD_HEARTBEAT, 4'd0, 1'b1, 1'b1, 1'b1));   // direct disabled
        drain_results();

        // Random phases, each with its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            cur = rand_cfg();
            if (ph == 0) begin
                cur.agent_mask             = 16'hFFFF;
                cur.poll_period_ticks      = 16'd0;
                cur.response_timeout_ticks = 16'd1;
                cur.direct_timeout_ticks   = 16'd1;
                cur.enable_direct          = 1'b1;
                cur.enable_acoustic        = 1'b1;
            end else if (ph == 1) begin
                cur.agent_mask             = 16'h8000;
                cur.poll_period_ticks      = 16'hFFFF;
                cur.response_timeout_ticks = 16'hFFFF;
                cur.direct_timeout_ticks   = 16'hFFFF;
            end
            write_config(cur);
            gaps_on = (ph % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send(next_request(cur.agent_mask));
                if ($urandom_range(0, 59) == 0) drain_results();
            end
            drain_results();
        end

        gaps_on = 1'b1;
        drain_results();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && reports_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
